// File: rtl/core/dda_line_rasterizer_assert.svh
// Assertion macros used by the line rasterizer checker.
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DDA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dda_line_rasterizer: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dda_line_rasterizer: assertion failed");

`endif

// File: rtl/core/dda_pkg.sv
// Package: shared types and codes for the DDA line rasterizer.
package dda_pkg;

    // Item command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_READY,
        ST_LOAD_X,
        ST_WAIT_X,
        ST_LOAD_Y,
        ST_WAIT_Y
    } dda_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } dda_div_stat_t;

endpackage

// File: rtl/core/dda_div.sv
// Iterative restoring divider: one quotient bit per cycle.
module dda_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_W-1:0]      numer,
    input  logic [DEN_W-1:0]      denom,
    output logic [NUM_W-1:0]      quot,
    output dda_pkg::dda_div_stat_t stat
);
    import dda_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] denom_reg, denom_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   sub_w;
    logic             fits;

    // Shift in the next dividend bit and try one subtract
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign sub_w = trial - {1'b0, denom_reg};
    assign fits  = (trial >= {1'b0, denom_reg});

    always_comb
    begin
        num_next   = num_reg;
        rem_next   = rem_reg;
        denom_next = denom_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            num_next   = numer;
            rem_next   = '0;
            denom_next = denom;
            cnt_next   = CNT_W'(NUM_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? sub_w[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        denom_reg <= denom_next;
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/core/dda_line_rasterizer.sv
// Top level: DDA line rasterizer with a shared iterative divider.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_stall  | cmd, start_x, start_y, end_x, end_y
//   output  | out_valid / out_stall| pixel_x, pixel_y, last_pixel
//
// Steps can be accepted back to back while the output register drains. A load
// of a zero-length line needs no division; any other load waits on the single
// restoring divider, which produces first the x and then the y increment one
// quotient bit per cycle. in_stall is high during the two divisions and
// whenever the output register holds a transaction that is stalled. Reset
// (rst_n low, asynchronous) returns the block to idle with no line active.
module dda_line_rasterizer #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);
    import dda_pkg::*;

    // Accumulator width: integer coordinate plus fraction
    localparam int ACC_W = COORD_BITS + FRAC_BITS;
    localparam int CNT_W = COORD_BITS + 1;

    dda_state_t state_reg, state_next;

    // Line setup held across the two divisions
    logic [COORD_BITS-1:0] adx_reg, adx_next;
    logic [COORD_BITS-1:0] ady_reg, ady_next;
    logic [COORD_BITS-1:0] steps_reg, steps_next;
    logic                  xneg_reg, xneg_next;
    logic                  yneg_reg, yneg_next;

    // Position accumulators and per-step increments (two's complement, mod 2^ACC_W)
    logic [ACC_W-1:0] x_acc_reg, x_acc_next;
    logic [ACC_W-1:0] y_acc_reg, y_acc_next;
    logic [ACC_W-1:0] x_inc_reg, x_inc_next;
    logic [ACC_W-1:0] y_inc_reg, y_inc_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             active_reg, active_next;

    // Output register
    logic                  ovalid_reg, ovalid_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic                  plast_reg, plast_next;

    // Load-time arithmetic
    logic                  ld_xneg, ld_yneg;
    logic [COORD_BITS-1:0] ld_adx, ld_ady, ld_steps;

    // Divider interface
    logic                  div_start;
    logic [ACC_W-1:0]      div_numer;
    logic [ACC_W-1:0]      div_quot;
    logic [ACC_W-1:0]      div_quot_neg;
    dda_div_stat_t         div_stat;

    logic out_free;
    logic in_take;
    logic is_last;

    assign out_free = !ovalid_reg || !out_stall;
    assign in_stall = (state_reg != ST_READY) || !out_free;
    assign in_take  = in_valid && !in_stall;
    assign is_last  = (left_reg <= CNT_W'(1));

    // Absolute deltas, direction and step count of the incoming line
    assign ld_xneg  = end_x < start_x;
    assign ld_yneg  = end_y < start_y;
    assign ld_adx   = ld_xneg ? start_x - end_x : end_x - start_x;
    assign ld_ady   = ld_yneg ? start_y - end_y : end_y - start_y;
    assign ld_steps = (ld_adx >= ld_ady) ? ld_adx : ld_ady;

    // Feed |d| << FRAC_BITS to the divider, x first then y
    assign div_numer    = (state_reg == ST_LOAD_X) ? {adx_reg, {FRAC_BITS{1'b0}}}
                                                   : {ady_reg, {FRAC_BITS{1'b0}}};
    assign div_quot_neg = ACC_W'(0) - div_quot;

    dda_div #(
        .NUM_W (ACC_W),
        .DEN_W (COORD_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (steps_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        steps_next  = steps_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        x_acc_next  = x_acc_reg;
        y_acc_next  = y_acc_reg;
        x_inc_next  = x_inc_reg;
        y_inc_next  = y_inc_reg;
        left_next   = left_reg;
        active_next = active_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        plast_next  = plast_reg;
        div_start   = 1'b0;
        // Drop the output transaction once taken
        ovalid_next = ovalid_reg && out_stall;

        case (state_reg)
            ST_READY:
            begin
                if (in_take && (cmd == CMD_LOAD))
                begin
                    // Replace any active line; seed at the start point
                    adx_next    = ld_adx;
                    ady_next    = ld_ady;
                    steps_next  = ld_steps;
                    xneg_next   = ld_xneg;
                    yneg_next   = ld_yneg;
                    x_acc_next  = {start_x, {FRAC_BITS{1'b0}}};
                    y_acc_next  = {start_y, {FRAC_BITS{1'b0}}};
                    x_inc_next  = '0;
                    y_inc_next  = '0;
                    left_next   = {1'b0, ld_steps} + CNT_W'(1);
                    active_next = 1'b1;
                    // Zero-length line needs no division
                    if (ld_steps != '0)
                    begin
                        state_next = ST_LOAD_X;
                    end
                end
                else if (in_take && active_reg)
                begin
                    // Emit the current pixel, then advance
                    ovalid_next = 1'b1;
                    px_next     = x_acc_reg[ACC_W-1:FRAC_BITS];
                    py_next     = y_acc_reg[ACC_W-1:FRAC_BITS];
                    plast_next  = is_last;
                    x_acc_next  = x_acc_reg + x_inc_reg;
                    y_acc_next  = y_acc_reg + y_inc_reg;
                    if (is_last)
                    begin
                        left_next   = '0;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        left_next = left_reg - CNT_W'(1);
                    end
                end
            end
            ST_LOAD_X:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (div_stat.done)
                begin
                    x_inc_next = xneg_reg ? div_quot_neg : div_quot;
                    state_next = ST_LOAD_Y;
                end
            end
            ST_LOAD_Y:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_Y;
            end
            ST_WAIT_Y:
            begin
                if (div_stat.done)
                begin
                    y_inc_next = yneg_reg ? div_quot_neg : div_quot;
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_READY;
            active_reg <= 1'b0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            left_reg   <= left_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg   <= adx_next;
        ady_reg   <= ady_next;
        steps_reg <= steps_next;
        xneg_reg  <= xneg_next;
        yneg_reg  <= yneg_next;
        x_acc_reg <= x_acc_next;
        y_acc_reg <= y_acc_next;
        x_inc_reg <= x_inc_next;
        y_inc_reg <= y_inc_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        plast_reg <= plast_next;
    end

    assign out_valid  = ovalid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last_pixel = plast_reg;

endmodule

// File: rtl/core/dda_chk.sv
// Port-level checker for the line rasterizer, bound to the top level.
`include "dda_line_rasterizer_assert.svh"

module dda_chk #(
    parameter int COORD_BITS = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  cmd,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic                  last_pixel
);
    import dda_pkg::*;

    logic in_take;
    logic load_take;
    logic step_take;

    assign in_take   = in_valid && !in_stall;
    assign load_take = in_take && (cmd == CMD_LOAD);
    assign step_take = in_take && (cmd == CMD_STEP);

    // A new output transaction only follows an accepted step
    `DDA_ASSERT_NEXT(a_out_from_step, !out_valid && !step_take, !out_valid)
    // A load never produces an output transaction
    `DDA_ASSERT_NEXT(a_load_silent, load_take && !out_valid, !out_valid)
    // A stalled output transaction stays
    `DDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))
    // No input is taken while a stalled output transaction waits
    `DDA_ASSERT_NOW(a_no_take_when_full, out_valid && out_stall, !in_take)

endmodule

bind dda_line_rasterizer dda_chk #(
    .COORD_BITS (COORD_BITS)
) u_dda_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
);
